// ===== sv/lrukt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukt_pkg
// Shared sizes, types and operation codes for the LRU key tracker.
// ----------------------------------------------------------------------------
package lrukt_pkg;

  localparam int ENTRIES   = 16;
  // Effective key width; the request key port is 32 bits, so keep this <= 32.
  localparam int KEY_WIDTH = 32;

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IDX_W  = RANK_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_TOUCH  = 3'd1,
    OP_ERASE  = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // Result of the parallel key compare and slot searches.
  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    idx_t free_idx;
    logic lru_found;
    idx_t lru_idx;
  } match_t;

endpackage

// ===== sv/lrukt_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukt_match
// Parallel key compare plus first-free and least-recent slot search.
// ----------------------------------------------------------------------------
module lrukt_match (
  input  lrukt_pkg::key_t                  key,
  input  lrukt_pkg::key_t                  keys  [lrukt_pkg::ENTRIES],
  input  logic [lrukt_pkg::ENTRIES-1:0]    valid,
  input  lrukt_pkg::rank_t                 ranks [lrukt_pkg::ENTRIES],
  input  lrukt_pkg::cnt_t                  count,
  output lrukt_pkg::match_t                match
);
  import lrukt_pkg::*;

  rank_t lru_rank;

  assign lru_rank = RANK_W'(count - cnt_t'(1));

  // Lowest index wins in every search.
  always_comb begin
    match = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && keys[i] == key) begin
        match.hit     = 1'b1;
        match.hit_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        match.free_idx = IDX_W'(i);
      end
      if (valid[i] && ranks[i] == lru_rank) begin
        match.lru_found = 1'b1;
        match.lru_idx   = IDX_W'(i);
      end
    end
  end

endmodule

// ===== sv/lru_key_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_tracker_core
// Least-recently-used key tracker with parallel key compare.
// ----------------------------------------------------------------------------
// Holds up to ENTRIES keys with a rank per slot (0 = most recent). Each request
// (insert, touch, erase, lookup, clear) yields exactly one result with found,
// evicted, evicted_key and occupancy. Throughput is one request per cycle while
// the result side takes results: a request is captured in an input register,
// and one pass of compare/rank-update logic then writes the tracker state and
// the result register. Stalls on the result side hold the input register; a
// new request is taken in the same cycle the held one moves on. State is
// updated only when a request moves to the result register, so back-to-back
// requests always see prior updates.
module lru_key_tracker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_req_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic        out_evicted,
  output logic [31:0] out_evicted_key,
  output logic [4:0]  out_occupancy
);
  import lrukt_pkg::*;

  // Tracker state
  key_t               key_r   [ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  rank_t              rank_r  [ENTRIES];
  rank_t              rank_nxt[ENTRIES];
  cnt_t               count_r, count_nxt;

  // Input register
  logic       stg_valid_r;
  logic [2:0] stg_func_r;
  key_t       stg_key_r;

  // Result register
  logic       out_valid_r;
  logic       found_r, evicted_r;
  key_t       ev_key_r;
  cnt_t       occ_r;

  logic   adv;
  match_t m;

  logic   found_c, evict_c, write_c, promote_c;
  key_t   ev_key_c;
  idx_t   sel;
  rank_t  pr;
  op_t    op;

  // Request in the input register moves on when the result slot frees up.
  assign adv      = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || adv;

  lrukt_match u_match (
    .key   (stg_key_r),
    .keys  (key_r),
    .valid (valid_r),
    .ranks (rank_r),
    .count (count_r),
    .match (m)
  );

  assign op = op_t'(stg_func_r);

  always_comb begin
    found_c   = 1'b0;
    evict_c   = 1'b0;
    write_c   = 1'b0;
    promote_c = 1'b0;
    ev_key_c  = '0;
    sel       = m.hit_idx;
    pr        = '0;
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    count_nxt = count_r;

    case (op)
      OP_INSERT: begin
        found_c = m.hit;
        if (m.hit) begin
          promote_c = 1'b1;
          pr        = rank_r[m.hit_idx];
        end else if (count_r >= cnt_t'(ENTRIES)) begin
          // full: reuse the least recent slot
          sel       = m.lru_found ? m.lru_idx : '0;
          evict_c   = 1'b1;
          ev_key_c  = key_r[sel];
          write_c   = 1'b1;
          promote_c = 1'b1;
          pr        = RANK_W'(count_r - cnt_t'(1));
        end else begin
          sel            = m.free_idx;
          valid_nxt[sel] = 1'b1;
          count_nxt      = count_r + cnt_t'(1);
          write_c        = 1'b1;
          promote_c      = 1'b1;
          pr             = RANK_W'(count_r);
        end
      end
      OP_TOUCH: begin
        found_c = m.hit;
        if (m.hit) begin
          promote_c = 1'b1;
          pr        = rank_r[m.hit_idx];
        end
      end
      OP_ERASE: begin
        found_c = m.hit;
        if (m.hit) begin
          valid_nxt[m.hit_idx] = 1'b0;
          rank_nxt[m.hit_idx]  = '0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_nxt[i] && rank_r[i] > rank_r[m.hit_idx]) begin
              rank_nxt[i] = rank_r[i] - rank_t'(1);
            end
          end
          count_nxt = count_r - cnt_t'(1);
        end
      end
      OP_LOOKUP: begin
        found_c = m.hit;
      end
      OP_CLEAR: begin
        valid_nxt = '0;
        for (int i = 0; i < ENTRIES; i++) begin
          rank_nxt[i] = '0;
        end
        count_nxt = '0;
      end
      default: begin
      end
    endcase

    // Promote: slots more recent than the target age by one, target to front.
    if (promote_c) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_nxt[i] && IDX_W'(i) != sel && rank_r[i] < pr) begin
          rank_nxt[i] = rank_r[i] + rank_t'(1);
        end
      end
      rank_nxt[sel] = '0;
    end
  end

  // Control and tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        stg_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        valid_r     <= valid_nxt;
        count_r     <= count_nxt;
        rank_r      <= rank_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_func_r <= in_func;
      stg_key_r  <= in_req_key[KEY_WIDTH-1:0];
    end
    if (adv) begin
      found_r   <= found_c;
      evicted_r <= evict_c;
      ev_key_r  <= ev_key_c;
      occ_r     <= count_nxt;
      if (write_c) begin
        key_r[sel] <= stg_key_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_evicted     = evicted_r;
  assign out_evicted_key = 32'(ev_key_r);
  assign out_occupancy   = 5'(occ_r);

  // Assertions
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(ENTRIES))
    else $error("occupancy above table size");

  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("occupancy does not match valid slots");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_found)
    else $error("eviction reported on a hit");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_occupancy == 5'(ENTRIES))
    else $error("eviction with table not full");

endmodule

// ===== test/lru_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_result_checker
// Watches both channels of the LRU key tracker, predicts and compares.
// ----------------------------------------------------------------------------
// Every request transfer is run through a local LRU table model and the
// outcome is queued. Every result transfer is compared field by field with
// the oldest queued outcome. Failures and progress are counted for the top.
// ----------------------------------------------------------------------------
module lru_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_req_key,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_found,
  input  logic        out_evicted,
  input  logic [31:0] out_evicted_key,
  input  logic [4:0]  out_occupancy,
  output int          fail_count,
  output int          pending,
  output int          checked_count,
  output int          hit_count,
  output int          eviction_count
);

  import lrukt_pkg::*;

  typedef struct packed {
    logic        found;
    logic        evicted;
    logic [31:0] evicted_key;
    logic [4:0]  occupancy;
  } outcome_t;

  // Local copy of the tracker table.
  key_t        slot_key  [ENTRIES];
  logic        slot_live [ENTRIES];
  int unsigned slot_rank [ENTRIES];
  int unsigned live_count;

  outcome_t outcomes_due[$];
  outcome_t want, seen;
  logic     differs;

  // Slot s becomes rank 0; everything more recent than it ages by one.
  task automatic make_most_recent(input int s);
    int unsigned r;
    r = slot_rank[s];
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_live[i] && slot_rank[i] < r) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endtask

  task automatic track_request(input logic [2:0] func, input logic [31:0] raw_key,
                               output outcome_t res);
    key_t        key;
    int          s;
    int unsigned r;
    key = raw_key[KEY_WIDTH-1:0];
    res = '0;
    s = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (s < 0 && slot_live[i] && slot_key[i] == key) s = i;
    end
    if (func == OP_CLEAR) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_live[i] = 1'b0;
        slot_rank[i] = 0;
      end
      live_count = 0;
    end else if (func <= OP_LOOKUP) begin
      res.found = (s >= 0);
      case (func)
        OP_INSERT: begin
          if (s >= 0) begin
            make_most_recent(s);
          end else begin
            if (live_count >= ENTRIES) begin
              // full: reuse the least recent slot
              for (int i = 0; i < ENTRIES; i++) begin
                if (s < 0 && slot_live[i] && slot_rank[i] == live_count - 1) s = i;
              end
              if (s < 0) s = 0;
              res.evicted = 1'b1;
              res.evicted_key[KEY_WIDTH-1:0] = slot_key[s];
            end else begin
              for (int i = 0; i < ENTRIES; i++) begin
                if (s < 0 && !slot_live[i]) s = i;
              end
              if (s < 0) s = 0;
              slot_live[s] = 1'b1;
              live_count++;
            end
            slot_key[s]  = key;
            slot_rank[s] = live_count - 1;
            make_most_recent(s);
          end
        end
        OP_TOUCH: begin
          if (s >= 0) make_most_recent(s);
        end
        OP_ERASE: begin
          if (s >= 0) begin
            r = slot_rank[s];
            slot_live[s] = 1'b0;
            slot_rank[s] = 0;
            for (int i = 0; i < ENTRIES; i++) begin
              if (slot_live[i] && slot_rank[i] > r) slot_rank[i]--;
            end
            if (live_count > 0) live_count--;
          end
        end
        default: ;
      endcase
    end
    res.occupancy = 5'(live_count);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i]  = '0;
        slot_live[i] = 1'b0;
        slot_rank[i] = 0;
      end
      live_count = 0;
      outcomes_due.delete();
    end else begin
      // result side first: a result never belongs to a request taken this edge
      if (out_valid && out_ready) begin
        seen = {out_found, out_evicted, out_evicted_key, out_occupancy};
        checked_count++;
        if (outcomes_due.size() == 0) begin
          $display("%0t ns: result with nothing expected: found %0b evicted %0b key %h occ %0d",
                   $time, seen.found, seen.evicted, seen.evicted_key, seen.occupancy);
          fail_count++;
        end else begin
          want = outcomes_due.pop_front();
          differs = 1'b0;
          if (seen.found !== want.found) begin
            $display("%0t ns: found expected %0b got %0b", $time, want.found, seen.found);
            differs = 1'b1;
          end
          if (seen.evicted !== want.evicted) begin
            $display("%0t ns: evicted expected %0b got %0b", $time, want.evicted,
                     seen.evicted);
            differs = 1'b1;
          end
          if (seen.evicted_key !== want.evicted_key) begin
            $display("%0t ns: evicted_key expected %h got %h", $time, want.evicted_key,
                     seen.evicted_key);
            differs = 1'b1;
          end
          if (seen.occupancy !== want.occupancy) begin
            $display("%0t ns: occupancy expected %0d got %0d", $time, want.occupancy,
                     seen.occupancy);
            differs = 1'b1;
          end
          if (differs) fail_count++;
        end
      end
      if (in_valid && in_ready) begin
        track_request(in_func, in_req_key, want);
        if (want.found) hit_count++;
        if (want.evicted) eviction_count++;
        // append at the tail, oldest stays at the front
        outcomes_due.insert(outcomes_due.size(), want);
      end
    end
    pending = outcomes_due.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the LRU key tracker core.
// ----------------------------------------------------------------------------
// A short directed sequence hits the empty table, hits and misses of every
// operation, the unused codes and clear. A random part then works from small
// rotating key pools so the table fills, evicts and churns. Both sides insert
// random gaps, with stretches of none, and the result side once holds off long
// enough to back the block up. Prediction and comparison live in the checker.
// ----------------------------------------------------------------------------
module testbench;

  import lrukt_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  localparam int POOL_SIZE    = 24;
  // One long result-side stall, taken after this many result transfers.
  localparam int STALL_AFTER  = 300;
  localparam int STALL_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_func;
  logic [31:0] in_req_key;
  logic        out_valid;
  logic        out_ready;
  logic        out_found;
  logic        out_evicted;
  logic [31:0] out_evicted_key;
  logic [4:0]  out_occupancy;

  int fail_count;
  int pending;
  int checked_count;
  int hit_count;
  int eviction_count;

  // Request count, and the "no idling" flag shared by both sides.
  int   sent_count;
  logic no_idle;

  logic [31:0] key_pool [POOL_SIZE];

  lru_key_tracker_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_req_key      (in_req_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .out_occupancy   (out_occupancy)
  );

  lru_result_checker result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_req_key      (in_req_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .out_occupancy   (out_occupancy),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked_count   (checked_count),
    .hit_count       (hit_count),
    .eviction_count  (eviction_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request; returns at the falling edge after its transfer.
  // Valid is only lowered when a gap is drawn, so back-to-back requests keep
  // it high across the edge.
  task automatic send_request(input logic [2:0] func, input logic [31:0] key);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= func;
    in_req_key <= key;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    // mostly pool keys so hits happen; now and then a fresh random key
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Result side: random hold-off per result, one long stall to fill the block.
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (taken == STALL_AFTER) hold = STALL_CYCLES;
      else hold = no_idle ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int       dice;
    logic [2:0] func;
    in_valid   = 1'b0;
    in_func    = OP_INSERT;
    in_req_key = '0;
    out_ready  = 1'b0;
    no_idle    = 1'b0;
    sent_count = 0;
    rst_n      = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed: empty table, hit/miss of each op, unused codes, clear ---
    send_request(OP_LOOKUP, 32'h0000_0000);   // lookup on empty table
    send_request(OP_TOUCH,  32'h0000_0000);   // touch absent
    send_request(OP_ERASE,  32'hFFFF_FFFF);   // erase absent
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h0000_0000);   // insert of a present key
    send_request(OP_TOUCH,  32'hFFFF_FFFF);   // touch present
    send_request(OP_LOOKUP, 32'h0000_0000);   // lookup present
    send_request(OP_LOOKUP, 32'h5A5A_A5A5);   // lookup absent
    send_request(OP_ERASE,  32'h0000_0000);   // erase present
    send_request(OP_ERASE,  32'h0000_0000);   // now absent
    send_request(3'd5, 32'hFFFF_FFFF);        // unused codes leave state alone
    send_request(3'd6, 32'h0000_0000);
    send_request(3'd7, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF);
    send_request(OP_CLEAR,  32'hFFFF_FFFF);   // clear with a non-empty table
    send_request(OP_LOOKUP, 32'hFFFF_FFFF);   // gone after clear
    send_request(OP_CLEAR,  32'h0000_0000);   // clear on empty table

    // --- random: pools larger than the table keep it full and evicting ---
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 200 == 0) begin
        foreach (key_pool[i]) key_pool[i] = $urandom;
      end
      // every fourth stretch of 120 requests runs without any idling
      no_idle = ((n / 120) % 4 == 3);
      dice = $urandom_range(0, 99);
      if (dice < 40) send_request(OP_INSERT, pick_key());
      else if (dice < 60) send_request(OP_TOUCH, pick_key());
      else if (dice < 75) send_request(OP_LOOKUP, pick_key());
      else if (dice < 90) send_request(OP_ERASE, pick_key());
      else if (dice < 92) send_request(OP_CLEAR, $urandom);
      else if (dice < 95) begin
        func = 3'($urandom_range(5, 7));
        send_request(func, $urandom);
      end else send_request(OP_INSERT, $urandom);
    end
    in_valid <= 1'b0;
    no_idle  = 1'b0;

    // drain, then keep watching for any stray result
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d requests: %0d hits and %0d evictions predicted, %0d results checked.",
             sent_count, hit_count, eviction_count, checked_count);
    $display("Covered directed edge cases, churn over rotating key pools and a long result stall.");
    if (fail_count == 0) begin
      $display("lru_key_tracker_core: match");
    end else begin
      $display("lru_key_tracker_core: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("lru_key_tracker_core: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lrukt_pkg.sv
sv/lrukt_match.sv
sv/lru_key_tracker_core.sv
test/lru_result_checker.sv
test/testbench.sv
